@@ rtl/core/cgra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgra_pkg
// shared constants, operation codes and control types of the read assignment core
// ----------------------------------------------------------------------------
package cgra_pkg;

	localparam int TRANSCRIPTS    = 4096;
	localparam int READS          = 65536;
	localparam int MAX_CANDIDATES = 64;

	localparam int FUNC_W = 2;
	localparam int RD_W   = 16;
	localparam int TR_W   = 12;
	localparam int CNT_W  = 18;
	localparam int PROB_W = 16;
	localparam int UNI_W  = 32;
	localparam int PC_W   = 16;
	localparam int CUM_W  = 48;
	localparam int V_W    = CNT_W + 9;          // count*256 + pseudo count, signed
	localparam int W_W    = V_W - 1 + PROB_W;   // weight of one candidate
	localparam int MUL_W  = 2 * UNI_W;

	localparam int TR_AW   = $clog2(TRANSCRIPTS);
	localparam int RD_AW   = $clog2(READS);
	localparam int CAND_AW = $clog2(MAX_CANDIDATES);
	localparam int FILL_W  = $clog2(MAX_CANDIDATES + 1);

	localparam int S_DATA_W = 96;
	localparam int M_DATA_W = 48;

	localparam logic [FUNC_W-1:0] FUNC_LOAD     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DRAW     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESAMPLE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd3;

	// count memory read address source
	localparam logic [1:0] CRD_TR     = 2'd0;
	localparam logic [1:0] CRD_OLD    = 2'd1;
	localparam logic [1:0] CRD_CHOSEN = 2'd2;

	// count memory write source
	localparam logic [1:0] CWR_CLEAR = 2'd0;
	localparam logic [1:0] CWR_LOAD  = 2'd1;
	localparam logic [1:0] CWR_DEC   = 2'd2;
	localparam logic [1:0] CWR_INC   = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

	typedef struct packed {
		logic               take;
		logic               cnt_rd;
		logic [1:0]         cnt_rsel;
		logic               cnt_wr;
		logic [1:0]         cnt_wsel;
		logic               ra_rd;
		logic               ra_wr;
		logic               mul_w;
		logic               acc;
		logic               th_hi;
		logic               th_lo;
		logic               th_sum;
		logic               sr_rd;
		logic               sr_take;
		logic               emit_asg;
		logic               emit_cnt;
		logic               end_read;
		logic [TR_AW-1:0]   clr_addr;
		logic [CAND_AW-1:0] sr_idx;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              last;
		logic              in_read;
		logic [FILL_W-1:0] fill;
		logic              hit;
		logic              out_busy;
	} sts_t;

endpackage

@@ rtl/core/cgra_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgra_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cgra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/cgra_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgra_ctrl
// sequencer of the read assignment core
// ----------------------------------------------------------------------------
module cgra_ctrl
	import cgra_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [4:0] ST_CLEAR  = 5'd0;
	localparam logic [4:0] ST_IDLE   = 5'd1;
	localparam logic [4:0] ST_DISP   = 5'd2;
	localparam logic [4:0] ST_CEMIT  = 5'd3;
	localparam logic [4:0] ST_DEC_RC = 5'd4;
	localparam logic [4:0] ST_DEC_WR = 5'd5;
	localparam logic [4:0] ST_W_RC   = 5'd6;
	localparam logic [4:0] ST_W_MUL  = 5'd7;
	localparam logic [4:0] ST_ACC    = 5'd8;
	localparam logic [4:0] ST_TH_HI  = 5'd9;
	localparam logic [4:0] ST_TH_LO  = 5'd10;
	localparam logic [4:0] ST_TH_SUM = 5'd11;
	localparam logic [4:0] ST_SR_RD  = 5'd12;
	localparam logic [4:0] ST_SR_CMP = 5'd13;
	localparam logic [4:0] ST_ASSIGN = 5'd14;
	localparam logic [4:0] ST_INC    = 5'd15;
	localparam logic [4:0] ST_AEMIT  = 5'd16;

	logic [4:0]         state_q, state_d;
	logic [TR_AW-1:0]   clr_q;
	logic [CAND_AW-1:0] idx_q;
	logic               idx_end;

	assign s_tready = (state_q == ST_IDLE);
	assign idx_end  = ({1'b0, idx_q} == FILL_W'(sts.fill - FILL_W'(1)));

	always_comb begin
		cmd          = '0;
		cmd.clr_addr = clr_q;
		cmd.sr_idx   = idx_q;
		state_d      = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.cnt_wr   = 1'b1;
				cmd.cnt_wsel = CWR_CLEAR;
				if (clr_q == TR_AW'(TRANSCRIPTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid) state_d = ST_DISP;
			end
			ST_DISP: begin
				unique case (sts.func)
					FUNC_LOAD: begin
						cmd.cnt_wr   = 1'b1;
						cmd.cnt_wsel = CWR_LOAD;
						state_d      = ST_IDLE;
					end
					FUNC_READ: begin
						cmd.cnt_rd   = 1'b1;
						cmd.cnt_rsel = CRD_TR;
						state_d      = ST_CEMIT;
					end
					FUNC_RESAMPLE: begin
						if (!sts.in_read) begin
							cmd.ra_rd = 1'b1;
							state_d   = ST_DEC_RC;
						end else begin
							cmd.cnt_rd   = 1'b1;
							cmd.cnt_rsel = CRD_TR;
							state_d      = ST_W_MUL;
						end
					end
					default: state_d = ST_W_MUL;
				endcase
			end
			ST_CEMIT: begin
				if (!sts.out_busy) begin
					cmd.emit_cnt = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_DEC_RC: begin
				cmd.cnt_rd   = 1'b1;
				cmd.cnt_rsel = CRD_OLD;
				state_d      = ST_DEC_WR;
			end
			ST_DEC_WR: begin
				cmd.cnt_wr   = 1'b1;
				cmd.cnt_wsel = CWR_DEC;
				state_d      = ST_W_RC;
			end
			ST_W_RC: begin
				cmd.cnt_rd   = 1'b1;
				cmd.cnt_rsel = CRD_TR;
				state_d      = ST_W_MUL;
			end
			ST_W_MUL: begin
				cmd.mul_w = 1'b1;
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? ST_TH_HI : ST_IDLE;
			end
			ST_TH_HI: begin
				cmd.th_hi = 1'b1;
				state_d   = ST_TH_LO;
			end
			ST_TH_LO: begin
				cmd.th_lo = 1'b1;
				state_d   = ST_TH_SUM;
			end
			ST_TH_SUM: begin
				cmd.th_sum = 1'b1;
				state_d    = ST_SR_RD;
			end
			ST_SR_RD: begin
				cmd.sr_rd = 1'b1;
				state_d   = ST_SR_CMP;
			end
			ST_SR_CMP: begin
				if (sts.hit || idx_end) begin
					cmd.sr_take = 1'b1;
					state_d     = ST_ASSIGN;
				end else begin
					state_d = ST_SR_RD;
				end
			end
			ST_ASSIGN: begin
				cmd.ra_wr    = 1'b1;
				cmd.cnt_rd   = 1'b1;
				cmd.cnt_rsel = CRD_CHOSEN;
				state_d      = ST_INC;
			end
			ST_INC: begin
				cmd.cnt_wr   = 1'b1;
				cmd.cnt_wsel = CWR_INC;
				state_d      = ST_AEMIT;
			end
			ST_AEMIT: begin
				if (!sts.out_busy) begin
					cmd.emit_asg = 1'b1;
					cmd.end_read = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + TR_AW'(1);
			if (cmd.th_sum) idx_q <= '0;
			else if (state_q == ST_SR_CMP && !cmd.sr_take) idx_q <= idx_q + CAND_AW'(1);
		end
	end

endmodule

@@ rtl/core/cgra_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgra_dp
// datapath: count, assignment and candidate memories, weights, draw, result register
// ----------------------------------------------------------------------------
module cgra_dp
	import cgra_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [FUNC_W-1:0]   s_tuser,
	input  logic                s_tlast,
	input  logic [PC_W-1:0]     pc,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser
);

	logic [FUNC_W-1:0] func_q;
	logic [RD_W-1:0]   rd_q;
	logic [TR_W-1:0]   tr_q;
	logic [CNT_W-1:0]  cv_q;
	logic [PROB_W-1:0] prob_q;
	logic              last_q;
	logic [UNI_W-1:0]  uni_q;

	logic [W_W-1:0]    w_q;
	logic [CUM_W-1:0]  total_q;
	logic [CUM_W-1:0]  prod_hi_q;
	logic [UNI_W-1:0]  prod_lo_q;
	logic [CUM_W-1:0]  thr_q;
	logic [TR_W-1:0]   chosen_q;
	logic [FILL_W-1:0] fill_q;
	logic              in_read_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [RD_W-1:0]   out_rd_q;
	logic [TR_W-1:0]   out_tr_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic [CNT_W-1:0]  cnt_rdata;
	logic [TR_W-1:0]   ra_rdata;
	logic [TR_W-1:0]   ids_rdata;
	logic [CUM_W-1:0]  cum_rdata;

	logic              cnt_we;
	logic [TR_AW-1:0]  cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0]  cnt_wdata;

	logic [V_W-1:0]    v;
	logic [W_W-1:0]    w_prod;
	logic [UNI_W-1:0]  mul_b;
	logic [MUL_W-1:0]  mul_p;
	logic [CUM_W:0]    sum;
	logic [CUM_W-1:0]  sum_sat;
	logic              room;

	// count memory port selection
	always_comb begin
		case (cmd.cnt_wsel)
			CWR_CLEAR: begin
				cnt_waddr = cmd.clr_addr;
				cnt_wdata = '0;
			end
			CWR_LOAD: begin
				cnt_waddr = tr_q[TR_AW-1:0];
				cnt_wdata = cv_q;
			end
			CWR_DEC: begin
				cnt_waddr = ra_rdata[TR_AW-1:0];
				cnt_wdata = (cnt_rdata == CNT_MIN) ? cnt_rdata : cnt_rdata - CNT_W'(1);
			end
			default: begin
				cnt_waddr = chosen_q[TR_AW-1:0];
				cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + CNT_W'(1);
			end
		endcase
		case (cmd.cnt_rsel)
			CRD_OLD:    cnt_raddr = ra_rdata[TR_AW-1:0];
			CRD_CHOSEN: cnt_raddr = chosen_q[TR_AW-1:0];
			default:    cnt_raddr = tr_q[TR_AW-1:0];
		endcase
	end

	assign cnt_we = cmd.cnt_wr;

	cgra_ram #(.WIDTH(CNT_W), .DEPTH(TRANSCRIPTS)) u_counts (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cmd.cnt_rd), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	cgra_ram #(.WIDTH(TR_W), .DEPTH(READS)) u_assign (
		.clk(clk), .we(cmd.ra_wr), .waddr(rd_q[RD_AW-1:0]), .wdata(chosen_q),
		.re(cmd.ra_rd), .raddr(rd_q[RD_AW-1:0]), .rdata(ra_rdata)
	);

	assign room = (fill_q != FILL_W'(MAX_CANDIDATES));

	cgra_ram #(.WIDTH(TR_W), .DEPTH(MAX_CANDIDATES)) u_ids (
		.clk(clk), .we(cmd.acc && room), .waddr(fill_q[CAND_AW-1:0]), .wdata(tr_q),
		.re(cmd.sr_rd), .raddr(cmd.sr_idx), .rdata(ids_rdata)
	);

	cgra_ram #(.WIDTH(CUM_W), .DEPTH(MAX_CANDIDATES)) u_cum (
		.clk(clk), .we(cmd.acc && room), .waddr(fill_q[CAND_AW-1:0]), .wdata(sum_sat),
		.re(cmd.sr_rd), .raddr(cmd.sr_idx), .rdata(cum_rdata)
	);

	// weight: (count*256 + pseudo count) * probability, zero when not positive
	assign v      = {cnt_rdata[CNT_W-1], cnt_rdata, 8'b0} + V_W'(pc);
	assign w_prod = v[V_W-2:0] * prob_q;

	// running sum saturates at the top of the 48 bit range
	assign sum     = {1'b0, total_q} + (CUM_W+1)'(w_q);
	assign sum_sat = sum[CUM_W] ? {CUM_W{1'b1}} : sum[CUM_W-1:0];

	// one shared 32x32 multiplier for both halves of uniform * total
	assign mul_b = cmd.th_hi ? UNI_W'(total_q[CUM_W-1:UNI_W]) : total_q[UNI_W-1:0];
	assign mul_p = uni_q * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= s_tuser;
			last_q <= s_tlast;
			rd_q   <= s_tdata[15:0];
			tr_q   <= s_tdata[27:16];
			cv_q   <= s_tdata[45:28];
			prob_q <= s_tdata[61:46];
			uni_q  <= s_tdata[93:62];
		end
		if (cmd.mul_w) begin
			if (func_q == FUNC_RESAMPLE) begin
				w_q <= (!v[V_W-1] && v != '0) ? w_prod : '0;
			end else begin
				w_q <= W_W'(prob_q);
			end
		end
		if (cmd.th_hi) prod_hi_q <= mul_p[CUM_W-1:0];
		if (cmd.th_lo) prod_lo_q <= mul_p[MUL_W-1:UNI_W];
		if (cmd.th_sum) thr_q <= prod_hi_q + CUM_W'(prod_lo_q);
		if (cmd.sr_take) chosen_q <= ids_rdata;
		if (cmd.emit_asg) begin
			out_kind_q <= 1'b0;
			out_rd_q   <= rd_q;
			out_tr_q   <= chosen_q;
			out_cnt_q  <= '0;
		end else if (cmd.emit_cnt) begin
			out_kind_q <= 1'b1;
			out_rd_q   <= '0;
			out_tr_q   <= tr_q;
			out_cnt_q  <= cnt_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			in_read_q   <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.end_read) begin
				fill_q    <= '0;
				in_read_q <= 1'b0;
				total_q   <= '0;
			end else if (cmd.acc) begin
				in_read_q <= 1'b1;
				if (room) begin
					fill_q  <= fill_q + FILL_W'(1);
					total_q <= sum_sat;
				end
			end
			if (cmd.emit_asg || cmd.emit_cnt) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign sts.func     = func_q;
	assign sts.last     = last_q;
	assign sts.in_read  = in_read_q;
	assign sts.fill     = fill_q;
	assign sts.hit      = (cum_rdata > thr_q);
	assign sts.out_busy = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {2'b0, out_cnt_q, out_tr_q, out_rd_q};

endmodule

@@ rtl/core/collapsed_gibbs_read_assignment_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collapsed_gibbs_read_assignment_core
// collapsed gibbs read-to-transcript assignment engine
// ----------------------------------------------------------------------------
// After reset the core clears its 4096-entry count memory, one entry a cycle, so
// it takes no beat until that pass is done (register writes are taken at any
// time). Items are then worked one at a time and the next beat is taken as soon
// as the sequencer returns to idle, even while a result still waits at the
// output register. A count load writes the count memory and a readback reads it.
// Draw and resample candidates form and accumulate their weights; a resample
// candidate that opens a read also reads the old assignment and decrements its
// count; all of it goes through the single read port of the count memory. The
// last candidate of a read adds a two-pass 32x32 multiply for the threshold and
// a linear search of the buffered cumulative weights, a read and a compare per
// entry up to the chosen one. A new result that meets a stalled output holds the
// sequencer until the old one leaves.
module collapsed_gibbs_read_assignment_core
	import cgra_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // read_index, transcript, count_value, probability, uniform
	input  logic [FUNC_W-1:0]   s_tuser,   // func
	input  logic                s_tlast,
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // read_index_out, chosen_transcript, count_out
	output logic                m_tuser,   // kind
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	cmd_t            cmd;
	sts_t            sts;
	logic [PC_W-1:0] pc_q;   // pseudo count, q8.8

	// register file: a single register at byte address 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'b0, pc_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_W'(256);
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			pc_q <= pwdata[PC_W-1:0];
		end
	end

	// sequencer
	cgra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	// memories, arithmetic and the result register
	cgra_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
		.pc(pc_q), .cmd(cmd), .sts(sts),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// candidate buffer never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.fill <= FILL_W'(MAX_CANDIDATES))
		else $error("candidate fill beyond buffer depth");

	// an emitted assignment leaves the buffer empty and the read closed
	a_read_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_asg |=> (sts.fill == '0 && !sts.in_read))
		else $error("read not closed after assignment");

	// a result is only loaded when the output slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_asg || cmd.emit_cnt) |-> !sts.out_busy)
		else $error("result register overwritten");

endmodule

@@ tb/sv/tb_collapsed_gibbs_read_assignment_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_collapsed_gibbs_read_assignment_core
// self-checking bench for the gibbs read assignment core: a predictor of the
// count memory, read assignments and candidate draw checks every result beat
// ----------------------------------------------------------------------------
module tb_collapsed_gibbs_read_assignment_core;
	import cgra_pkg::*;

	localparam int          LIMIT_CYCLES = 1000000;
	localparam int          N_ITEMS      = 1550;
	localparam int          REG_PC       = 0;
	localparam logic [2:0]  ADDR_PC      = 3'(4 * REG_PC);
	localparam logic [47:0] CUM_SAT      = 48'hFFFF_FFFF_FFFF;
	localparam logic        KIND_ASSIGN  = 1'b0;
	localparam logic        KIND_COUNT   = 1'b1;

	typedef struct {
		logic [FUNC_W-1:0]       func;
		logic [RD_W-1:0]         rd;
		logic [TR_W-1:0]         tr;
		logic signed [CNT_W-1:0] cnt;
		logic [PROB_W-1:0]       prob;
		logic                    last;
		logic [UNI_W-1:0]        uni;
	} item_t;

	typedef struct {
		logic                    kind;
		logic [RD_W-1:0]         rd;
		logic [TR_W-1:0]         tr;
		logic signed [CNT_W-1:0] cnt;
	} result_t;

	// predictor of the sampler plus the queue of assignments and counts still owed
	class assignment_scoreboard;
		logic signed [CNT_W-1:0] counts[TRANSCRIPTS];
		logic [TR_W-1:0]         assign_of[READS];
		bit                      assigned[READS];
		int                      assigned_reads[$];
		logic [TR_W-1:0]         cand_tr[MAX_CANDIDATES];
		logic [CUM_W-1:0]        cand_cum[MAX_CANDIDATES];
		int                      fill;
		bit                      open_read;
		logic [PC_W-1:0]         pc_val;
		result_t                 owed[$];
		int                      errors;

		function new();
			foreach (counts[i]) counts[i] = '0;
			fill      = 0;
			open_read = 0;
			pc_val    = 16'd256;
			errors    = 0;
		endfunction

		function void bump(logic [TR_W-1:0] t, int d);
			int v;
			v = int'(counts[t]) + d;
			if (v > 131071) v = 131071;
			if (v < -131072) v = -131072;
			counts[t] = CNT_W'(v);
		endfunction

		function void note_beat(item_t it);
			longint      v;
			logic [47:0] w, prev, total, thr;
			logic [79:0] prod;
			logic [48:0] sum;
			result_t     r;
			int          k;
			if (it.func == FUNC_LOAD) begin
				counts[it.tr] = it.cnt;
				return;
			end
			if (it.func == FUNC_READ) begin
				r.kind = KIND_COUNT; r.rd = '0; r.tr = it.tr; r.cnt = counts[it.tr];
				owed.insert(owed.size(), r);
				return;
			end
			if (it.func == FUNC_RESAMPLE) begin
				if (!open_read) bump(assign_of[it.rd], -1);
				v = longint'(counts[it.tr]) * 256 + longint'(pc_val);
				w = (v > 0) ? 48'(v * longint'(it.prob)) : '0;
			end else begin
				w = 48'(it.prob);
			end
			open_read = 1;
			if (fill < MAX_CANDIDATES) begin
				prev = fill ? cand_cum[fill-1] : '0;
				sum  = prev + w;
				cand_tr[fill]  = it.tr;
				cand_cum[fill] = sum[48] ? CUM_SAT : sum[47:0];
				fill++;
			end
			if (!it.last) return;
			total = cand_cum[fill-1];
			prod  = {48'b0, it.uni} * {32'b0, total};
			thr   = prod[79:32];
			k     = fill - 1;
			for (int j = 0; j < fill; j++)
				if (cand_cum[j] > thr) begin
					k = j;
					break;
				end
			assign_of[it.rd] = cand_tr[k];
			if (!assigned[it.rd]) begin
				assigned[it.rd] = 1;
				assigned_reads.insert(assigned_reads.size(), int'(it.rd));
			end
			bump(cand_tr[k], 1);
			fill = 0;
			open_read = 0;
			r.kind = KIND_ASSIGN; r.rd = it.rd; r.tr = cand_tr[k]; r.cnt = '0;
			owed.insert(owed.size(), r);
		endfunction

		function void check_beat(logic kind, logic [M_DATA_W-1:0] data);
			result_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result beat kind %0d data %h", $time, kind, data);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (kind !== e.kind) begin
				$display("%0t: kind expected %0d got %0d", $time, e.kind, kind);
				errors++;
			end
			if (data[15:0] !== e.rd) begin
				$display("%0t: read index expected %0d got %0d", $time, e.rd, data[15:0]);
				errors++;
			end
			if (data[27:16] !== e.tr) begin
				$display("%0t: transcript expected %0d got %0d", $time, e.tr, data[27:16]);
				errors++;
			end
			if (data[45:28] !== e.cnt) begin
				$display("%0t: count expected %0d got %0d", $time, e.cnt,
					$signed(data[45:28]));
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // read_index, transcript, count_value, probability, uniform
	logic [FUNC_W-1:0]   s_tuser;   // func
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // read_index_out, chosen_transcript, count_out
	logic                m_tuser;   // kind
	logic                psel, penable, pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata, prdata;
	logic                pready;

	collapsed_gibbs_read_assignment_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	assignment_scoreboard sb = new();
	int  cycles     = 0;
	int  sent       = 0;
	int  received   = 0;
	int  burst_left = 0;
	int  max_gap    = 8;
	bit  held       = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// run limit: covers the clearing pass, long searches and stalls several times over
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_collapsed_gibbs_read_assignment_core failed");
			$finish;
		end
	end

	// result side: random stall pattern, one long hold-off to back the core up
	initial begin
		int hold_left;
		int stall_pct;
		hold_left = 0;
		stall_pct = 0;
		m_tready  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cycles % 64 == 0) stall_pct = ($urandom_range(0, 2)) * 35;
			if (!held && received >= 150) begin
				held      = 1;
				hold_left = 500;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 0;
			end else begin
				m_tready = ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_beat(m_tuser, m_tdata);
			received <= received + 1;
		end
	end

	// one input beat, sent in bursts with idle gaps between them
	task automatic push(item_t it);
		@(negedge clk);
		if (burst_left == 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(0, max_gap)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tdata  = {2'b0, it.uni, it.prob, it.cnt, it.tr, it.rd};
		s_tuser  = it.func;
		s_tlast  = it.last;
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		sb.note_beat(it);
		burst_left--;
		sent++;
	endtask

	task automatic put(logic [FUNC_W-1:0] f, int rd, int tr, int cnt, int prob,
			bit last, logic [31:0] uni);
		item_t it;
		it.func = f; it.rd = RD_W'(rd); it.tr = TR_W'(tr); it.cnt = CNT_W'(cnt);
		it.prob = PROB_W'(prob); it.last = last; it.uni = uni;
		push(it);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
		sb.pc_val = data[PC_W-1:0];
	endtask

	// wait for the owed results, then let a final search finish
	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		burst_left = 0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic int rand_tr();
		return ($urandom_range(0, 9) < 6) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
	endfunction

	// loads or readbacks, sometimes with last raised
	task automatic side_op();
		int cnt;
		cnt = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 65537)) - 1
			: int'($urandom_range(0, 262143));
		if ($urandom_range(0, 1))
			put(FUNC_LOAD, $urandom, rand_tr(), cnt, $urandom, $urandom_range(0, 1), $urandom);
		else
			put(FUNC_READ, $urandom, rand_tr(), 0, $urandom, $urandom_range(0, 1), $urandom);
	endtask

	// one read: mostly well-formed candidate runs, now and then mixed or overfull
	task automatic gen_read();
		int                n, rd, rd_out, prob;
		logic [FUNC_W-1:0] f, cf;
		bit                resample;
		n = ($urandom_range(0, 49) == 0) ? $urandom_range(65, 70) : $urandom_range(1, 6);
		resample = sb.assigned_reads.size() != 0 && $urandom_range(0, 9) < 7;
		if (resample) begin
			f  = FUNC_RESAMPLE;
			rd = sb.assigned_reads[$urandom_range(0, sb.assigned_reads.size() - 1)];
		end else begin
			f  = FUNC_DRAW;
			rd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 63);
		end
		for (int i = 0; i < n; i++) begin
			cf = f;
			if (i > 0 && $urandom_range(0, 9) == 0)
				cf = (f == FUNC_DRAW) ? FUNC_RESAMPLE : FUNC_DRAW;
			if (i > 0 && $urandom_range(0, 19) == 0) side_op();
			rd_out = (i == n - 1 && $urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : rd;
			prob = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
			put(cf, (i == 0) ? rd : rd_out, rand_tr(), 0, prob, i == n - 1, $urandom);
			if (sent >= N_ITEMS && i == n - 1) break;
		end
	endtask

	initial begin
		logic [31:0] pc_values[4];
		s_tvalid = 0; s_tdata = '0; s_tuser = FUNC_LOAD; s_tlast = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed part at the reset pseudo count of 1.0
		reg_write(ADDR_PC, 32'd256);
		put(FUNC_LOAD, 0, 0, 0, 0, 0, 0);
		put(FUNC_LOAD, 0, 4095, 65536, 0, 0, 0);
		put(FUNC_LOAD, 0, 5, -1, 0, 0, 0);
		put(FUNC_LOAD, 0, 8, 131071, 0, 0, 0);
		put(FUNC_LOAD, 0, 7, -131072, 0, 1, 0);
		put(FUNC_READ, 0, 4095, 0, 0, 1, 0);
		put(FUNC_READ, 0, 7, 0, 0, 0, 0);
		// two candidate draw with the top uniform
		put(FUNC_DRAW, 0, 5, 0, 16'hFFFF, 0, 0);
		put(FUNC_DRAW, 0, 8, 0, 0, 1, 32'hFFFF_FFFF);
		// zero total falls to the last candidate
		put(FUNC_DRAW, 65535, 4095, 0, 0, 1, 0);
		// increment at the top count limit
		put(FUNC_DRAW, 1, 8, 0, 1, 1, 0);
		put(FUNC_READ, 0, 8, 0, 0, 0, 0);
		put(FUNC_DRAW, 2, 7, 0, 100, 1, 0);
		put(FUNC_LOAD, 0, 7, -131072, 0, 0, 0);
		// resample opening on a read held by a count at the bottom limit
		put(FUNC_RESAMPLE, 2, 9, 0, 16'hFFFF, 0, 0);
		// load and readback inside a read, with last ignored
		put(FUNC_LOAD, 0, 3, 10, 0, 1, 0);
		put(FUNC_READ, 0, 3, 0, 0, 1, 0);
		// mixed operations and a different read index on the last candidate
		put(FUNC_DRAW, 2, 7, 0, 16'hFFFF, 0, 0);
		put(FUNC_RESAMPLE, 3, 4095, 0, 16'hFFFF, 1, 32'h8000_0000);
		put(FUNC_READ, 0, 7, 0, 0, 0, 0);
		put(FUNC_READ, 0, 9, 0, 0, 0, 0);
		drain();

		// random phases over the pseudo count extremes
		pc_values[0] = 32'd0;
		pc_values[1] = 32'd65535;
		pc_values[2] = $urandom_range(0, 65535);
		pc_values[3] = 32'd1;
		for (int p = 0; p < 4; p++) begin
			reg_write(ADDR_PC, pc_values[p]);
			max_gap = (p == 2) ? 0 : 10;
			while (sent < 21 + (p + 1) * (N_ITEMS - 21) / 4) begin
				if ($urandom_range(0, 9) < 2) side_op();
				else gen_read();
			end
			drain();
		end

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("tb_collapsed_gibbs_read_assignment_core passed");
		else
			$display("tb_collapsed_gibbs_read_assignment_core failed");
		$finish;
	end

endmodule
